// File: hdl/csfdo_pkg.sv
package csfdo_pkg;

  // Default sizes
  localparam int STORE_DEPTH_DEF = 32768;
  localparam int MAX_CHUNK_DEF   = 4096;
  localparam int CHUNK_SLOTS_DEF = 256;

  // Fixed field widths
  localparam int SAMPLE_W = 16;
  localparam int LEN_IN_W = 13;
  localparam int FILL_W   = 16;
  localparam int CFG_W    = 16;
  localparam int REQ_W    = 2;

  // Working width for sums and compares against the cap (store depth up to 65536)
  localparam int WIDE_W = 17;

  localparam logic [CFG_W-1:0] CAP_RESET = 16'd24000;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_PUSH  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_POP   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

endpackage

// File: hdl/csfdo_ram.sv
module csfdo_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Register the read data every cycle
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// File: hdl/chunked_sample_fifo_drop_oldest.sv
// Channel   Direction  Handshake                    Payload
// request   in         start / busy                 req_type, sample_in, chunk_start, chunk_len
// result    out        result_valid (strobe)        sample_out, sample_valid, dropped, fill_level
// config    in         cfg_valid / cfg_ready        cfg_data (cap_samples)
//
// Pop, clear and a push without chunk_start pass through the EXEC state to the result strobe.
// A push that opens a chunk passes CLOSE, WAIT, EVAL and FINISH; each chunk that it drops
// to fit the cap sends it back through WAIT for the registered read of the chunk length
// ring, and a drop for a full slot ring goes straight from EVAL to FINISH.
// busy is high from the transfer until the result strobe; rst is synchronous and clears
// all control state; the sample store and length ring are not cleared.
// Results cannot be stalled: each one is on the ports for exactly one cycle.
module chunked_sample_fifo_drop_oldest #(
  parameter int STORE_DEPTH = csfdo_pkg::STORE_DEPTH_DEF,
  parameter int MAX_CHUNK   = csfdo_pkg::MAX_CHUNK_DEF,
  parameter int CHUNK_SLOTS = csfdo_pkg::CHUNK_SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [csfdo_pkg::REQ_W-1:0]    req_type,
  input  logic signed [csfdo_pkg::SAMPLE_W-1:0] sample_in,
  input  logic                           chunk_start,
  input  logic [csfdo_pkg::LEN_IN_W-1:0] chunk_len,
  output logic                           result_valid,
  output logic signed [csfdo_pkg::SAMPLE_W-1:0] sample_out,
  output logic                           sample_valid,
  output logic                           dropped,
  output logic [csfdo_pkg::FILL_W-1:0]   fill_level,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [csfdo_pkg::CFG_W-1:0]    cfg_data
);

  import csfdo_pkg::*;

  localparam int PW    = $clog2(STORE_DEPTH);
  localparam int CW    = $clog2(CHUNK_SLOTS);
  localparam int NW    = $clog2(CHUNK_SLOTS + 1);
  localparam int LIMIT = (MAX_CHUNK < STORE_DEPTH) ? MAX_CHUNK : STORE_DEPTH;
  localparam int LW    = $clog2(LIMIT + 1);
  localparam int TW    = $clog2(STORE_DEPTH + 1);

  localparam logic [WIDE_W-1:0] DEPTH_W   = WIDE_W'(STORE_DEPTH);
  localparam logic [WIDE_W-1:0] LIMIT_W   = WIDE_W'(LIMIT);
  localparam logic [PW:0]       DEPTH_P   = (PW+1)'(STORE_DEPTH);
  localparam logic [PW-1:0]     PTR_LAST  = PW'(STORE_DEPTH - 1);
  localparam logic [CW-1:0]     SLOT_LAST = CW'(CHUNK_SLOTS - 1);
  localparam logic [NW-1:0]     SLOT_FULL = NW'(CHUNK_SLOTS);

  // Sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_CLOSE  = 3'd2;
  localparam logic [2:0] S_WAIT   = 3'd3;
  localparam logic [2:0] S_EVAL   = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  logic [2:0]          state;
  logic [REQ_W-1:0]    req_q;
  logic [SAMPLE_W-1:0] sample_q;
  logic [LW-1:0]       len_q;
  logic                drop_flag;
  logic [CFG_W-1:0]    cap;

  logic [CW-1:0] head;
  logic [CW-1:0] tail;
  logic [NW-1:0] count;
  logic [PW-1:0] rp;
  logic [PW-1:0] wp;
  logic [LW-1:0] head_off;
  logic [TW-1:0] total;
  logic [LW-1:0] pending;
  logic [LW-1:0] open_len;

  logic [SAMPLE_W-1:0] store_q;
  logic [LW-1:0]       ring_q;

  logic                store_we;
  logic                ring_we;
  logic [CW-1:0]       ring_wa;
  logic [LW-1:0]       ring_wd;

  logic [WIDE_W-1:0] len_in_w;
  logic [LW-1:0]     len_sat;
  logic [WIDE_W-1:0] cap_eff;
  logic [WIDE_W-1:0] sub_a;
  logic [WIDE_W-1:0] sub_b;
  logic [WIDE_W-1:0] sub_y;
  logic [WIDE_W-1:0] unread;
  logic [TW-1:0]     total_drop;
  logic [PW:0]       rp_sum;
  logic [PW-1:0]     rp_drop;
  logic [CW-1:0]     head_inc;
  logic [CW-1:0]     tail_inc;
  logic [CW-1:0]     tail_last;
  logic [PW-1:0]     rp_inc;
  logic [PW-1:0]     wp_inc;
  logic              need_drop;
  logic              pop_ok;
  logic [LW-1:0]     hoff_inc;
  logic              q_empty;
  logic [TW-1:0]     total_fin;
  logic [TW-1:0]     total_exec;

  assign busy      = rst || (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // Saturate the incoming chunk length; a zero length is taken as one
  assign len_in_w = WIDE_W'(chunk_len);
  always_comb begin
    if (len_in_w == '0) begin
      len_sat = LW'(1);
    end else if (len_in_w > LIMIT_W) begin
      len_sat = LW'(LIMIT_W);
    end else begin
      len_sat = LW'(len_in_w);
    end
  end

  // Effective cap never exceeds the store
  assign cap_eff = (WIDE_W'(cap) > DEPTH_W) ? DEPTH_W : WIDE_W'(cap);

  // Shared subtractor: shortens an open chunk on close, counts unread samples on drop
  always_comb begin
    sub_a = '0;
    sub_b = '0;
    if (state == S_CLOSE) begin
      sub_a = WIDE_W'(open_len);
      sub_b = WIDE_W'(pending);
    end else if (state == S_EVAL) begin
      sub_a = WIDE_W'(ring_q);
      sub_b = WIDE_W'(head_off);
    end
  end
  assign sub_y = sub_a - sub_b;

  // Drop of the front chunk
  assign unread     = (ring_q > head_off) ? sub_y : '0;
  assign total_drop = (unread <= WIDE_W'(total)) ? TW'(WIDE_W'(total) - unread) : '0;
  assign rp_sum     = (PW+1)'(rp) + (PW+1)'(unread);
  assign rp_drop    = (rp_sum >= DEPTH_P) ? PW'(rp_sum - DEPTH_P) : PW'(rp_sum);
  assign need_drop  = (count != '0) && ((WIDE_W'(total) + WIDE_W'(len_q)) > cap_eff);

  // Ring and pointer steps
  assign head_inc  = (head == SLOT_LAST) ? '0 : head + 1'b1;
  assign tail_inc  = (tail == SLOT_LAST) ? '0 : tail + 1'b1;
  assign tail_last = (tail == '0) ? SLOT_LAST : tail - 1'b1;
  assign rp_inc    = (rp == PTR_LAST) ? '0 : rp + 1'b1;
  assign wp_inc    = (wp == PTR_LAST) ? '0 : wp + 1'b1;

  // Pop only from completed chunks
  assign pop_ok   = (count != '0) && !((count == NW'(1)) && (pending != '0));
  assign hoff_inc = head_off + 1'b1;

  // Totals after the item
  assign q_empty   = (count == '0);
  assign total_fin = (q_empty ? '0 : total) + TW'(len_q);
  always_comb begin
    total_exec = total;
    if (req_q == REQ_CLEAR) begin
      total_exec = '0;
    end else if (req_q == REQ_POP && pop_ok && total != '0) begin
      total_exec = total - 1'b1;
    end
  end

  // Memory write ports
  assign store_we = (state == S_FINISH) ||
                    ((state == S_EXEC) && (req_q == REQ_PUSH) && (pending != '0));
  assign ring_we  = (state == S_FINISH) ||
                    ((state == S_CLOSE) && (pending != '0) && (count != '0));
  assign ring_wa  = (state == S_CLOSE) ? tail_last : tail;
  assign ring_wd  = (state == S_CLOSE) ? LW'(sub_y) : len_q;

  csfdo_ram #(
    .DEPTH (STORE_DEPTH),
    .WIDTH (SAMPLE_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (store_we),
    .wr_addr (wp),
    .wr_data (sample_q),
    .rd_addr (rp),
    .rd_data (store_q)
  );

  csfdo_ram #(
    .DEPTH (CHUNK_SLOTS),
    .WIDTH (LW)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ring_we),
    .wr_addr (ring_wa),
    .wr_data (ring_wd),
    .rd_addr (head),
    .rd_data (ring_q)
  );

  // Capture the request
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_q    <= req_type;
      sample_q <= sample_in;
      len_q    <= len_sat;
    end
  end

  // Cap register
  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cap <= cfg_data;
    end
  end

  // Sequencer and queue state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      head         <= '0;
      tail         <= '0;
      count        <= '0;
      rp           <= '0;
      wp           <= '0;
      head_off     <= '0;
      total        <= '0;
      pending      <= '0;
      open_len     <= '0;
      drop_flag    <= 1'b0;
      result_valid <= 1'b0;
      sample_out   <= '0;
      sample_valid <= 1'b0;
      dropped      <= 1'b0;
      fill_level   <= '0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            drop_flag <= 1'b0;
            state <= (req_type == REQ_PUSH && chunk_start) ? S_CLOSE : S_EXEC;
          end
        end
        S_EXEC: begin
          sample_out   <= '0;
          sample_valid <= 1'b0;
          dropped      <= 1'b0;
          fill_level   <= FILL_W'(total_exec);
          result_valid <= 1'b1;
          total        <= total_exec;
          if (req_q == REQ_PUSH) begin
            // append to the open chunk, ignore an orphan sample
            if (pending != '0) begin
              wp      <= wp_inc;
              pending <= pending - 1'b1;
            end
          end else if (req_q == REQ_POP) begin
            if (pop_ok) begin
              sample_out   <= store_q;
              sample_valid <= 1'b1;
              rp           <= rp_inc;
              if (hoff_inc >= ring_q) begin
                head     <= head_inc;
                count    <= count - 1'b1;
                head_off <= '0;
              end else begin
                head_off <= hoff_inc;
              end
            end
          end else if (req_q == REQ_CLEAR) begin
            head     <= '0;
            tail     <= '0;
            count    <= '0;
            rp       <= wp;
            head_off <= '0;
            pending  <= '0;
          end
          state <= S_IDLE;
        end
        S_CLOSE: begin
          // shorten an unfinished chunk and release its reservation
          if (pending != '0 && count != '0) begin
            total <= total - TW'(pending);
          end
          pending <= '0;
          state   <= S_WAIT;
        end
        S_WAIT: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          if (need_drop || count == SLOT_FULL) begin
            total     <= total_drop;
            rp        <= rp_drop;
            head      <= head_inc;
            count     <= count - 1'b1;
            head_off  <= '0;
            drop_flag <= 1'b1;
            state     <= need_drop ? S_WAIT : S_FINISH;
          end else begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          // open the new chunk with its first sample
          if (q_empty) begin
            rp       <= wp;
            head_off <= '0;
          end
          total        <= total_fin;
          tail         <= tail_inc;
          count        <= count + 1'b1;
          wp           <= wp_inc;
          pending      <= len_q - 1'b1;
          open_len     <= len_q;
          sample_out   <= '0;
          sample_valid <= 1'b0;
          dropped      <= drop_flag;
          fill_level   <= FILL_W'(total_fin);
          result_valid <= 1'b1;
          state        <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // An accepted request keeps the block busy until its result
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("block not busy after request transfer");

  // The result strobe ends the item
  a_result_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (state == S_IDLE))
    else $error("result strobe while sequencer still active");

  // Chunk count stays within the ring
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= SLOT_FULL)
    else $error("chunk count above slot count");

  // An open chunk is always in the ring
  a_pending_chunk: assert property (@(posedge clk) disable iff (rst)
    (pending != '0) |-> (count != '0))
    else $error("open chunk with no chunk held");

  // The held total never exceeds the store
  a_total_max: assert property (@(posedge clk) disable iff (rst)
    WIDE_W'(total) <= DEPTH_W)
    else $error("sample total above store depth");

endmodule
